// ===== hdl/wide_to_utf8_encoder_core_defines.svh =====
// Assertion macros for the wide to UTF-8 encoder core.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef WIDE_TO_UTF8_ENCODER_CORE_DEFINES_SVH
`define WIDE_TO_UTF8_ENCODER_CORE_DEFINES_SVH

`define W2U8_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("w2u8 assertion failed");

`define W2U8_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("w2u8 assertion failed");

`endif

// ===== hdl/w2u8_pkg.sv =====
// Types, constants and the code point encoding function of the wide to UTF-8 encoder.
// Depends on nothing; every other file of the block but the assertion macros header uses it.
package w2u8_pkg;

  localparam int CP_W    = 21;
  localparam int BYTE_W  = 8;
  localparam int SEQ_MAX = 4;
  localparam int IDX_W   = $clog2(SEQ_MAX);
  localparam int LEN_W   = $clog2(SEQ_MAX + 1);
  localparam int HELD_W  = 10;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CP_W-1:0] SURR_HIGH_MIN = CP_W'(24'h00D800);
  localparam logic [CP_W-1:0] SURR_HIGH_MAX = CP_W'(24'h00DBFF);
  localparam logic [CP_W-1:0] SURR_LOW_MIN  = CP_W'(24'h00DC00);
  localparam logic [CP_W-1:0] SURR_LOW_MAX  = CP_W'(24'h00DFFF);
  localparam logic [CP_W-1:0] CP_SUPP_BASE  = CP_W'(24'h010000);
  localparam logic [CP_W-1:0] CP_2BYTE_MIN  = CP_W'(24'h000080);
  localparam logic [CP_W-1:0] CP_3BYTE_MIN  = CP_W'(24'h000800);
  localparam logic [CP_W-1:0] CP_4BYTE_MIN  = CP_W'(24'h010000);

  localparam logic [BYTE_W-1:0] LEAD_2 = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_3 = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_4 = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT   = 8'h80;

  localparam logic [LEN_W-1:0] LEN_NONE = LEN_W'(0);
  localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_TWO  = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_THREE = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_FOUR = LEN_W'(4);

  typedef struct packed {
    logic [SEQ_MAX-1:0][BYTE_W-1:0] bytes;
    logic [LEN_W-1:0]               len;
  } enc_t;

  // A job is the output of one input word: one sequence, optionally followed by another.
  typedef struct packed {
    enc_t seg0;
    enc_t seg1;
    logic last;
  } job_t;

  function automatic enc_t encode_cp(input logic [CP_W-1:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp < CP_2BYTE_MIN) begin
      e.len      = LEN_ONE;
      e.bytes[0] = cp[BYTE_W-1:0];
    end else if (cp < CP_3BYTE_MIN) begin
      e.len      = LEN_TWO;
      e.bytes[0] = LEAD_2 | {3'b000, cp[10:6]};
      e.bytes[1] = CONT | {2'b00, cp[5:0]};
    end else if (cp < CP_4BYTE_MIN) begin
      e.len      = LEN_THREE;
      e.bytes[0] = LEAD_3 | {4'b0000, cp[15:12]};
      e.bytes[1] = CONT | {2'b00, cp[11:6]};
      e.bytes[2] = CONT | {2'b00, cp[5:0]};
    end else begin
      e.len      = LEN_FOUR;
      e.bytes[0] = LEAD_4 | {5'b00000, cp[20:18]};
      e.bytes[1] = CONT | {2'b00, cp[17:12]};
      e.bytes[2] = CONT | {2'b00, cp[11:6]};
      e.bytes[3] = CONT | {2'b00, cp[5:0]};
    end
    return e;
  endfunction

endpackage

// ===== hdl/w2u8_ifs.sv =====
// Valid/ready channel interfaces for the input code units and the output UTF-8 bytes.
// Depends on w2u8_pkg for the payload widths.
interface w2u8_in_if;
  logic                       valid;
  logic                       ready;
  logic [w2u8_pkg::CP_W-1:0]  code_unit;
  logic                       string_end;

  modport source (output valid, output code_unit, output string_end, input ready);
  modport sink (input valid, input code_unit, input string_end, output ready);
endinterface

interface w2u8_out_if;
  logic                         valid;
  logic                         ready;
  logic [w2u8_pkg::BYTE_W-1:0]  utf8_byte;
  logic                         run_last;
  logic                         string_done;

  modport source (output valid, output utf8_byte, output run_last, output string_done,
                  input ready);
  modport sink (input valid, input utf8_byte, input run_last, input string_done,
                output ready);
endinterface

// ===== hdl/wide_to_utf8_encoder_core.sv =====
// Top level of the wide code unit to UTF-8 encoder.
// Depends on w2u8_pkg, w2u8_ifs, w2u8_front, w2u8_fifo and w2u8_back.
//
// Each input word carries one UTF-16 unit or code point and a string end mark; each
// output word carries one UTF-8 byte, marked on the last byte of its input word and on
// the final byte of the string. A high surrogate that does not end the string is held and
// produces no output until the next unit arrives; it then pairs with a low surrogate into
// a four byte sequence, or is sent alone as three bytes ahead of the next unit's bytes.
// The output register sends one byte per cycle while out_ch.ready is high. A unit yields
// one to four bytes, up to seven when a held surrogate is flushed, none when it is only
// held. The front end accepts a new unit every cycle while the two-entry job queue has
// room; a unit's bytes pass the job queue, the current job register and the output register.
module wide_to_utf8_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  w2u8_in_if.sink     in_ch,
  w2u8_out_if.source  out_ch
);
  import w2u8_pkg::*;

  job_t front_job, queue_job;
  logic front_valid, front_ready;
  logic queue_valid, queue_ready;

  w2u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  w2u8_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (queue_job),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready)
  );

  w2u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (queue_job),
    .job_valid (queue_valid),
    .job_ready (queue_ready),
    .out_ch    (out_ch)
  );

endmodule

// ===== hdl/w2u8_front.sv =====
// Front end: accepts code units, pairs surrogates and encodes each word into a job.
// Depends on w2u8_pkg and w2u8_ifs.
module w2u8_front (
  input  logic            clk,
  input  logic            rst_n,
  w2u8_in_if.sink         in_ch,
  output w2u8_pkg::job_t  job,
  output logic            job_valid,
  input  logic            job_ready
);
  import w2u8_pkg::*;

  logic [HELD_W-1:0] held_bits_r, held_bits_nxt;
  logic              held_valid_r, held_valid_nxt;
  logic              accept;
  logic              is_high, is_low, hold_new;
  logic [CP_W-1:0]   combined_cp, flush_cp;

  assign is_high  = (in_ch.code_unit >= SURR_HIGH_MIN) && (in_ch.code_unit <= SURR_HIGH_MAX);
  assign is_low   = (in_ch.code_unit >= SURR_LOW_MIN) && (in_ch.code_unit <= SURR_LOW_MAX);
  assign hold_new = is_high && !in_ch.string_end;

  assign combined_cp = CP_SUPP_BASE + {1'b0, held_bits_r, in_ch.code_unit[HELD_W-1:0]};
  assign flush_cp    = SURR_HIGH_MIN | {{(CP_W-HELD_W){1'b0}}, held_bits_r};

  assign in_ch.ready = job_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign job_valid   = in_ch.valid && (held_valid_r || !hold_new);

  always_comb begin
    job.last     = in_ch.string_end;
    job.seg1     = '0;
    job.seg1.len = LEN_NONE;
    if (held_valid_r) begin
      if (is_low) begin
        job.seg0 = encode_cp(combined_cp);
      end else begin
        job.seg0 = encode_cp(flush_cp);
        if (!hold_new) begin
          job.seg1 = encode_cp(in_ch.code_unit);
        end
      end
    end else begin
      job.seg0 = encode_cp(in_ch.code_unit);
    end
  end

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_bits_nxt  = held_bits_r;
    if (accept) begin
      held_valid_nxt = hold_new;
      if (hold_new) begin
        held_bits_nxt = in_ch.code_unit[HELD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_bits_r  <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_bits_r  <= held_bits_nxt;
    end
  end

endmodule

// ===== hdl/w2u8_fifo.sv =====
// Two-entry job queue between the front end and the byte serialiser.
// Depends on w2u8_pkg.
module w2u8_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  w2u8_pkg::job_t  push_data,
  input  logic            push_valid,
  output logic            push_ready,
  output w2u8_pkg::job_t  pop_data,
  output logic            pop_valid,
  input  logic            pop_ready
);
  import w2u8_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/w2u8_back.sv =====
// Back end: walks through the bytes of each job and sends one word per cycle while out_ch.ready is high.
// Depends on w2u8_pkg, w2u8_ifs and the assertion macros header.
`include "wide_to_utf8_encoder_core_defines.svh"

module w2u8_back (
  input  logic            clk,
  input  logic            rst_n,
  input  w2u8_pkg::job_t  job,
  input  logic            job_valid,
  output logic            job_ready,
  w2u8_out_if.source      out_ch
);
  import w2u8_pkg::*;

  job_t              cur_r, cur_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic              seg_r, seg_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_run_last_r, out_run_last_nxt;
  logic              out_done_r, out_done_nxt;

  logic [LEN_W-1:0]  seg_len;
  logic [BYTE_W-1:0] cur_byte;
  logic              seg_end, run_end, emit, load;

  assign seg_len  = seg_r ? cur_r.seg1.len : cur_r.seg0.len;
  assign cur_byte = seg_r ? cur_r.seg1.bytes[idx_r] : cur_r.seg0.bytes[idx_r];
  assign seg_end  = ({{(LEN_W-IDX_W){1'b0}}, idx_r} == (seg_len - LEN_ONE));
  assign run_end  = seg_end && (seg_r || (cur_r.seg1.len == LEN_NONE));
  assign emit     = cur_valid_r && (!out_valid_r || out_ch.ready);

  assign job_ready = !cur_valid_r || (emit && run_end);
  assign load      = job_valid && job_ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.utf8_byte   = out_byte_r;
  assign out_ch.run_last    = out_run_last_r;
  assign out_ch.string_done = out_done_r;

  always_comb begin
    cur_nxt          = cur_r;
    cur_valid_nxt    = cur_valid_r;
    seg_nxt          = seg_r;
    idx_nxt          = idx_r;
    out_valid_nxt    = out_valid_r;
    out_byte_nxt     = out_byte_r;
    out_run_last_nxt = out_run_last_r;
    out_done_nxt     = out_done_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (emit) begin
      out_valid_nxt    = 1'b1;
      out_byte_nxt     = cur_byte;
      out_run_last_nxt = run_end;
      out_done_nxt     = run_end && cur_r.last;
      if (run_end) begin
        cur_valid_nxt = 1'b0;
      end else if (seg_end) begin
        seg_nxt = 1'b1;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end

    if (load) begin
      cur_nxt       = job;
      cur_valid_nxt = 1'b1;
      seg_nxt       = 1'b0;
      idx_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_byte_r <= out_byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r    <= 1'b0;
      seg_r          <= 1'b0;
      idx_r          <= '0;
      out_valid_r    <= 1'b0;
      out_run_last_r <= 1'b0;
      out_done_r     <= 1'b0;
    end else begin
      cur_valid_r    <= cur_valid_nxt;
      seg_r          <= seg_nxt;
      idx_r          <= idx_nxt;
      out_valid_r    <= out_valid_nxt;
      out_run_last_r <= out_run_last_nxt;
      out_done_r     <= out_done_nxt;
    end
  end

  `W2U8_ASSERT_IMPL(a_done_is_run_last, out_valid_r && out_done_r, out_run_last_r)
  `W2U8_ASSERT_IMPL(a_first_seq_present, cur_valid_r, cur_r.seg0.len != LEN_NONE)
  `W2U8_ASSERT_IMPL(a_second_seq_present, cur_valid_r && seg_r, cur_r.seg1.len != LEN_NONE)
  `W2U8_ASSERT_NEXT(a_emit_fills_output, emit, out_valid_r)

endmodule
